// File: src/bitmap_slot_allocator_with_resident_page_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap slot allocator
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_WITH_RESIDENT_PAGE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_WITH_RESIDENT_PAGE_MACROS_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsa assertion failed");

// next-cycle implication
`define BSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsa assertion failed");

`endif

// File: src/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Types and constants of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MAX_LARGE_PAGES = 256;
  localparam int SLOTS_PER_PAGE  = 16;
  localparam int PAGE_W          = 8;
  localparam int SLOT_W          = 4;
  localparam int CNT_W           = 9;
  localparam int GROUP_SZ        = 16;
  localparam int NUM_GROUPS      = MAX_LARGE_PAGES / GROUP_SZ;
  localparam int GRP_W           = 4;
  localparam int IDX_W           = 4;
  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = CNT_W'(256);

  typedef enum logic [1:0] {
    CMD_ALLOC        = 2'd0,
    CMD_FREE         = 2'd1,
    CMD_MAKE_CURRENT = 2'd2
  } cmd_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GRP  = 6'b000010,
    S_SEL  = 6'b000100,
    S_PAGE = 6'b001000,
    S_AMOD = 6'b010000,
    S_FMOD = 6'b100000
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] page_index;
    logic [SLOT_W-1:0] slot_index;
    logic              modified;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] alloc_page;
    logic [SLOT_W-1:0] alloc_slot;
    logic              write_back;
    logic [PAGE_W-1:0] write_back_page;
    logic              fetch;
    logic [PAGE_W-1:0] fetch_page;
  } rsp_t;

endpackage

// File: src/bitmap_slot_allocator_with_resident_page.sv
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_with_resident_page
// Slot allocator over per-page occupancy words held in a synchronous RAM,
// with a page-full summary vector and resident page / dirty tracking.
// ----------------------------------------------------------------------------
// channel  | ports                      | handshake
// request  | in_req                     | start & !busy
// result   | out_rsp                    | out_strobe, one cycle, no stall
// config   | cfg_wdata (page_count)     | cfg_we
//
// Allocate: accepted, then group scan, group pick, page pick, RAM read-modify-
//   write; result strobes after the write, busy until the write is made; with no
//   free slot the result follows the group pick.
// Free: one RAM read-modify-write, busy while the write is made.
// Make-current and unused commands: result next cycle, busy stays low.
// Reset needs no clearing pass: per-page valid bits make unwritten words zero.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_with_resident_page_macros.svh"

module bitmap_slot_allocator_with_resident_page (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bsa_pkg::req_t              in_req,
  output logic                       out_strobe,
  output bsa_pkg::rsp_t              out_rsp,
  input  logic                       cfg_we,
  input  logic [bsa_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int NP = bsa_pkg::MAX_LARGE_PAGES;
  localparam int NS = bsa_pkg::SLOTS_PER_PAGE;
  localparam int PW = bsa_pkg::PAGE_W;
  localparam int SW = bsa_pkg::SLOT_W;
  localparam int CW = bsa_pkg::CNT_W;
  localparam int GS = bsa_pkg::GROUP_SZ;
  localparam int NG = bsa_pkg::NUM_GROUPS;
  localparam int GW = bsa_pkg::GRP_W;
  localparam int IW = bsa_pkg::IDX_W;

  logic [NS-1:0] slot_bitmap_mem [NP];
  logic [NS-1:0] rd_data_r;
  logic          mem_we;
  logic          mem_re;
  logic [PW-1:0] mem_waddr;
  logic [PW-1:0] mem_raddr;
  logic [NS-1:0] mem_wdata;

  bsa_pkg::state_t state_r, state_nxt;
  bsa_pkg::req_t   req_r, req_nxt;
  bsa_pkg::rsp_t   out_rsp_r, out_rsp_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  logic [CW-1:0]   page_count_r, page_count_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   start_r, start_nxt;
  logic [NG-1:0]   ghi_r, ghi_nxt;
  logic [NG-1:0]   glo_r, glo_nxt;
  logic [GW-1:0]   g_r, g_nxt;
  logic            hi_sel_r, hi_sel_nxt;
  logic [PW-1:0]   pg_r, pg_nxt;
  logic [NP-1:0]   valid_r, valid_nxt;
  logic [NP-1:0]   full_r, full_nxt;
  logic [PW-1:0]   resident_r, resident_nxt;
  logic            dirty_r, dirty_nxt;

  logic [CW-1:0]   cap_cnt;
  logic [PW-1:0]   start_sel;
  logic [NG-1:0]   ghi_c;
  logic [NG-1:0]   glo_c;
  logic            grp_hit;
  logic            grp_hi;
  logic [GW-1:0]   grp_idx;
  logic [GS-1:0]   grp_full;
  logic [IW-1:0]   pick_j;
  logic [PW-1:0]   pick_page;
  logic [NS-1:0]   word_cur;
  logic [SW-1:0]   free_slot;
  logic [NS-1:0]   word_alloc;
  logic [NS-1:0]   word_freed;
  logic            dirty_eff;

  // RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_bitmap_mem[mem_raddr];
    end
  end

  always_comb begin
    cap_cnt   = (page_count_r > CW'(NP)) ? CW'(NP) : page_count_r;
    start_sel = ({1'b0, resident_r} < cap_cnt) ? resident_r : '0;
  end

  // per-group candidate summary
  always_comb begin
    ghi_c = '0;
    glo_c = '0;
    for (int g = 0; g < NG; g++) begin
      for (int j = 0; j < GS; j++) begin
        if (!full_r[g*GS + j] && (CW'(g*GS + j) < cnt_r)) begin
          glo_c[g] = 1'b1;
          if (PW'(g*GS + j) >= start_r) begin
            ghi_c[g] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    grp_hit = 1'b0;
    grp_hi  = 1'b0;
    grp_idx = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (glo_r[g]) begin
        grp_idx = GW'(g);
        grp_hit = 1'b1;
      end
    end
    for (int g = NG - 1; g >= 0; g--) begin
      if (ghi_r[g]) begin
        grp_idx = GW'(g);
        grp_hi  = 1'b1;
      end
    end
  end

  always_comb begin
    grp_full = full_r[{g_r, IW'(0)} +: GS];
    pick_j   = '0;
    for (int j = GS - 1; j >= 0; j--) begin
      if (!grp_full[j] && ({1'b0, g_r, IW'(j)} < cnt_r) &&
          (!hi_sel_r || ({g_r, IW'(j)} >= start_r))) begin
        pick_j = IW'(j);
      end
    end
    pick_page = {g_r, pick_j};
  end

  always_comb begin
    word_cur  = valid_r[pg_r] ? rd_data_r : '0;
    free_slot = '0;
    for (int j = NS - 1; j >= 0; j--) begin
      if (!word_cur[j]) begin
        free_slot = SW'(j);
      end
    end
    word_alloc = word_cur | (NS'(1) << free_slot);
    word_freed = word_cur & ~(NS'(1) << req_r.slot_index);
    dirty_eff  = dirty_r | in_req.modified;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    cnt_nxt        = cnt_r;
    start_nxt      = start_r;
    ghi_nxt        = ghi_r;
    glo_nxt        = glo_r;
    g_nxt          = g_r;
    hi_sel_nxt     = hi_sel_r;
    pg_nxt         = pg_r;
    valid_nxt      = valid_r;
    full_nxt       = full_r;
    resident_nxt   = resident_r;
    dirty_nxt      = dirty_r;
    page_count_nxt = cfg_we ? cfg_wdata : page_count_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = '0;
    mem_we         = 1'b0;
    mem_waddr      = pg_r;
    mem_wdata      = word_alloc;
    mem_re         = 1'b0;
    mem_raddr      = pg_r;
    case (state_r)
      bsa_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          case (in_req.cmd)
            bsa_pkg::CMD_ALLOC: begin
              cnt_nxt   = cap_cnt;
              start_nxt = start_sel;
              state_nxt = bsa_pkg::S_GRP;
            end
            bsa_pkg::CMD_FREE: begin
              mem_re    = 1'b1;
              mem_raddr = in_req.page_index;
              pg_nxt    = in_req.page_index;
              state_nxt = bsa_pkg::S_FMOD;
            end
            bsa_pkg::CMD_MAKE_CURRENT: begin
              out_strobe_nxt = 1'b1;
              out_rsp_nxt.ok = 1'b1;
              dirty_nxt      = dirty_eff;
              if (in_req.page_index != resident_r) begin
                dirty_nxt                   = 1'b0;
                resident_nxt                = in_req.page_index;
                out_rsp_nxt.write_back      = dirty_eff;
                out_rsp_nxt.write_back_page = dirty_eff ? resident_r : '0;
                out_rsp_nxt.fetch           = 1'b1;
                out_rsp_nxt.fetch_page      = in_req.page_index;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      bsa_pkg::S_GRP: begin
        ghi_nxt   = ghi_c;
        glo_nxt   = glo_c;
        state_nxt = bsa_pkg::S_SEL;
      end
      bsa_pkg::S_SEL: begin
        if (grp_hit) begin
          g_nxt      = grp_idx;
          hi_sel_nxt = grp_hi;
          state_nxt  = bsa_pkg::S_PAGE;
        end else begin
          out_strobe_nxt = 1'b1;
          state_nxt      = bsa_pkg::S_IDLE;
        end
      end
      bsa_pkg::S_PAGE: begin
        pg_nxt    = pick_page;
        mem_re    = 1'b1;
        mem_raddr = pick_page;
        state_nxt = bsa_pkg::S_AMOD;
      end
      bsa_pkg::S_AMOD: begin
        mem_we                 = 1'b1;
        mem_wdata              = word_alloc;
        valid_nxt[pg_r]        = 1'b1;
        full_nxt[pg_r]         = &word_alloc;
        out_strobe_nxt         = 1'b1;
        out_rsp_nxt.ok         = 1'b1;
        out_rsp_nxt.alloc_page = pg_r;
        out_rsp_nxt.alloc_slot = free_slot;
        state_nxt              = bsa_pkg::S_IDLE;
      end
      bsa_pkg::S_FMOD: begin
        mem_we          = 1'b1;
        mem_wdata       = word_freed;
        valid_nxt[pg_r] = 1'b1;
        full_nxt[pg_r]  = 1'b0;
        out_strobe_nxt  = 1'b1;
        out_rsp_nxt.ok  = 1'b1;
        state_nxt       = bsa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bsa_pkg::S_IDLE;
      out_strobe_r <= 1'b0;
      page_count_r <= bsa_pkg::PAGE_COUNT_RST;
      valid_r      <= '0;
      full_r       <= '0;
      resident_r   <= '0;
      dirty_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      page_count_r <= page_count_nxt;
      valid_r      <= valid_nxt;
      full_r       <= full_nxt;
      resident_r   <= resident_nxt;
      dirty_r      <= dirty_nxt;
    end
    req_r     <= req_nxt;
    cnt_r     <= cnt_nxt;
    start_r   <= start_nxt;
    ghi_r     <= ghi_nxt;
    glo_r     <= glo_nxt;
    g_r       <= g_nxt;
    hi_sel_r  <= hi_sel_nxt;
    pg_r      <= pg_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != bsa_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  `BSA_ASSERT_NXT(a_alloc_goes_busy,
    start && !busy && (in_req.cmd == bsa_pkg::CMD_ALLOC), busy)
  `BSA_ASSERT_NOW(a_picked_page_not_full,
    state_r == bsa_pkg::S_AMOD, !full_r[pg_r] && ({1'b0, pg_r} < cnt_r))
  `BSA_ASSERT_NOW(a_write_back_with_fetch,
    out_strobe && out_rsp.write_back, out_rsp.fetch && out_rsp.ok)

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for bitmap_slot_allocator_with_resident_page
// Directed rows, then random phases at several page counts and idle rates;
// each result is checked against a typed response or a local copy of the allocator state.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_DIR = 24;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 105;

  typedef struct packed {
    logic                      is_cfg;
    logic [bsa_pkg::CNT_W-1:0] cfg_val;
    bsa_pkg::req_t             req;
    logic                      typed;
    bsa_pkg::rsp_t             want;
  } dir_row_t;

  typedef struct packed {
    logic [bsa_pkg::PAGE_W-1:0] page;
    logic [bsa_pkg::SLOT_W-1:0] slot;
  } slot_ref_t;

  localparam bsa_pkg::req_t NO_REQ = '0;
  localparam bsa_pkg::rsp_t RSP_NONE = '0;
  localparam bsa_pkg::rsp_t RSP_OK = '{1'b1, 8'd0, 4'd0, 1'b0, 8'd0, 1'b0, 8'd0};

  // is_cfg, cfg_val, request, typed, typed response
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd0, 4'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd255, 4'd15, 1'b1}, 1'b1,
      '{1'b1, 8'd0, 4'd1, 1'b0, 8'd0, 1'b0, 8'd0}},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_FREE, 8'd0, 4'd0, 1'b0}, 1'b1, RSP_OK},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd0, 4'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_FREE, 8'd255, 4'd15, 1'b1}, 1'b1, RSP_OK},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd0, 4'd0, 1'b1}, 1'b1, RSP_OK},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd255, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd0, 4'd0, 1'b1, 8'd0, 1'b1, 8'd255}},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd255, 4'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd255, 4'd15, 1'b1}, 1'b1, RSP_OK},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd128, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd0, 4'd0, 1'b1, 8'd255, 1'b1, 8'd128}},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd200, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd0, 4'd0, 1'b0, 8'd0, 1'b1, 8'd200}},
    '{1'b0, 9'd0, '{bsa_pkg::cmd_t'(CMD_UNUSED), 8'd255, 4'd15, 1'b1}, 1'b1,
      RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_FREE, 8'd255, 4'd0, 1'b0}, 1'b1, RSP_OK},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd200, 4'd0, 1'b0, 8'd0, 1'b0, 8'd0}},
    '{1'b1, 9'd1, NO_REQ, 1'b0, RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b0, RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd0, 4'd0, 1'b1}, 1'b0, RSP_NONE},
    '{1'b1, 9'd0, NO_REQ, 1'b0, RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b1, RSP_NONE},
    '{1'b1, 9'd511, NO_REQ, 1'b0, RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b0, RSP_NONE},
    '{1'b1, 9'd256, NO_REQ, 1'b0, RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_MAKE_CURRENT, 8'd255, 4'd0, 1'b0}, 1'b0, RSP_NONE},
    '{1'b0, 9'd0, '{bsa_pkg::CMD_ALLOC, 8'd0, 4'd0, 1'b0}, 1'b0, RSP_NONE}
  };

  localparam int PHASE_PAGES [NUM_PHASES] = '{1, 2, 3, 17, 0, 511, 257, 2, 256};
  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 54, 11, 0, 54, 11, 0, 54, 0};

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  bsa_pkg::req_t             in_req;
  logic                      out_strobe;
  bsa_pkg::rsp_t             out_rsp;
  logic                      cfg_we;
  logic [bsa_pkg::CNT_W-1:0] cfg_wdata;

  // allocator state as seen by the checker
  logic [bsa_pkg::SLOTS_PER_PAGE-1:0] occ_words [bsa_pkg::MAX_LARGE_PAGES];
  logic [bsa_pkg::PAGE_W-1:0]         res_page;
  logic                               res_dirty;
  int unsigned                        pool_pages;

  bsa_pkg::rsp_t rsp_due [$];
  slot_ref_t     held_slots [$];
  int            errors;

  bitmap_slot_allocator_with_resident_page i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL bitmap_slot_allocator_with_resident_page");
    $finish;
  end

  function automatic bsa_pkg::rsp_t compute_rsp(bsa_pkg::req_t r);
    bsa_pkg::rsp_t o;
    int unsigned   cnt;
    int unsigned   first;
    int unsigned   p;
    int unsigned   n;
    int unsigned   s;
    o = '0;
    case (r.cmd)
      bsa_pkg::CMD_ALLOC: begin
        cnt = (pool_pages > bsa_pkg::MAX_LARGE_PAGES) ? bsa_pkg::MAX_LARGE_PAGES
                                                      : pool_pages;
        first = (32'(res_page) < cnt) ? 32'(res_page) : 0;
        for (n = 0; n < cnt && !o.ok; n++) begin
          p = (first + n) % cnt;
          for (s = 0; s < bsa_pkg::SLOTS_PER_PAGE && !o.ok; s++) begin
            if (!occ_words[bsa_pkg::PAGE_W'(p)][bsa_pkg::SLOT_W'(s)]) begin
              occ_words[bsa_pkg::PAGE_W'(p)][bsa_pkg::SLOT_W'(s)] = 1'b1;
              o.ok = 1'b1;
              o.alloc_page = bsa_pkg::PAGE_W'(p);
              o.alloc_slot = bsa_pkg::SLOT_W'(s);
            end
          end
        end
      end
      bsa_pkg::CMD_FREE: begin
        occ_words[r.page_index][r.slot_index] = 1'b0;
        o.ok = 1'b1;
      end
      bsa_pkg::CMD_MAKE_CURRENT: begin
        if (r.modified) res_dirty = 1'b1;
        if (r.page_index != res_page) begin
          if (res_dirty) begin
            o.write_back = 1'b1;
            o.write_back_page = res_page;
            res_dirty = 1'b0;
          end
          res_page = r.page_index;
          o.fetch = 1'b1;
          o.fetch_page = r.page_index;
        end
        o.ok = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_req(bsa_pkg::req_t r, logic typed, bsa_pkg::rsp_t want);
    bsa_pkg::rsp_t pred;
    @(negedge clk);
    start = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    pred = compute_rsp(r);
    if (r.cmd == bsa_pkg::CMD_ALLOC && pred.ok) begin
      held_slots.push_back('{pred.alloc_page, pred.alloc_slot});
    end
    rsp_due.push_back(typed ? want : pred);
  endtask

  task automatic idle_gap(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic drain_rsp();
    @(negedge clk);
    start = 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_page_count(int unsigned v);
    drain_rsp();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = bsa_pkg::CNT_W'(v);
    pool_pages = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_req(output bsa_pkg::req_t r);
    int unsigned pick;
    int unsigned hi;
    int unsigned idx;
    r.page_index = bsa_pkg::PAGE_W'($urandom);
    r.slot_index = bsa_pkg::SLOT_W'($urandom);
    r.modified = 1'($urandom);
    hi = (pool_pages > 254) ? 255 : pool_pages + 1;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.cmd = bsa_pkg::CMD_ALLOC;
    end else if (pick < 76) begin
      r.cmd = bsa_pkg::CMD_FREE;
      if (held_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, held_slots.size() - 1);
        r.page_index = held_slots[idx].page;
        r.slot_index = held_slots[idx].slot;
        held_slots.delete(idx);
      end
    end else if (pick < 95) begin
      r.cmd = bsa_pkg::CMD_MAKE_CURRENT;
      case ($urandom_range(0, 3))
        0: r.page_index = res_page;
        1, 2: r.page_index = bsa_pkg::PAGE_W'($urandom_range(0, hi));
        default: ;
      endcase
    end else begin
      r.cmd = bsa_pkg::cmd_t'(CMD_UNUSED);
    end
  endtask

  task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bsa_pkg::rsp_t want;
    if (rst_n && out_strobe) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none actual %h",
                 $time, out_rsp);
        errors++;
      end else begin
        want = rsp_due.pop_front();
        check_field("ok", 32'(want.ok), 32'(out_rsp.ok));
        check_field("alloc_page", 32'(want.alloc_page), 32'(out_rsp.alloc_page));
        check_field("alloc_slot", 32'(want.alloc_slot), 32'(out_rsp.alloc_slot));
        check_field("write_back", 32'(want.write_back), 32'(out_rsp.write_back));
        check_field("write_back_page", 32'(want.write_back_page),
                    32'(out_rsp.write_back_page));
        check_field("fetch", 32'(want.fetch), 32'(out_rsp.fetch));
        check_field("fetch_page", 32'(want.fetch_page), 32'(out_rsp.fetch_page));
      end
    end
  end

  initial begin
    bsa_pkg::req_t r;
    int            ph;
    int            n;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    errors = 0;
    res_page = '0;
    res_dirty = 1'b0;
    pool_pages = 32'(bsa_pkg::PAGE_COUNT_RST);
    for (n = 0; n < bsa_pkg::MAX_LARGE_PAGES; n++) occ_words[bsa_pkg::PAGE_W'(n)] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (n = 0; n < NUM_DIR; n++) begin
      if (DIR_ROWS[n].is_cfg) set_page_count(32'(DIR_ROWS[n].cfg_val));
      else send_req(DIR_ROWS[n].req, DIR_ROWS[n].typed, DIR_ROWS[n].want);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_page_count(PHASE_PAGES[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // occasional full stop until every outstanding request has answered
        if ($urandom_range(0, 49) == 0) drain_rsp();
        if ($urandom_range(0, 99) < PHASE_IDLE[ph]) idle_gap($urandom_range(1, 4));
        random_req(r);
        send_req(r, 1'b0, RSP_NONE);
      end
    end

    drain_rsp();
    if (errors == 0) begin
      $display("PASS bitmap_slot_allocator_with_resident_page");
    end else begin
      $display("FAIL bitmap_slot_allocator_with_resident_page");
    end
    $finish;
  end

endmodule
